[rtl/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

	// Window length register: width and reset value
	localparam int unsigned WL_W = 7;
	localparam logic [WL_W-1:0] WL_RESET = 7'd3;

	// Per-cycle command broadcast along the cell row
	typedef struct packed {
		logic load;   // a request is taken this cycle
		logic shift;  // front entry leaves, every cell takes its right neighbor
		logic clear;  // end of sequence, all cells go empty
	} swm_ctrl_t;

endpackage

[rtl/sliding_window_maximum.sv]
`timescale 1ns / 1ps

// Sliding-window maximum over a stream of signed samples.
// Input channel: sample / last_of_sequence with sample_valid, sample_stall.
// Output channel: window_max / sequence_end with result_valid, result_stall.
// A request is taken when valid is high and stall is low.
// From the sample that completes the first window_length of a sequence on,
// every sample gives one result: the maximum of the latest window_length
// samples. Before that, no result (also for a last sample, which still
// ends the sequence). Results are registered and appear in the cycle after
// the sample is taken; one sample per cycle while the receiver keeps up and
// no trim is pending. A result held by result_stall blocks the input
// until taken. After window_length is lowered, the row drops the extra
// expired entries one per cycle while holding sample_stall high.
// window_length is written through window_length_write; write only while
// idle. Reset empties the row, clears counters, sets window_length to 3.
module sliding_window_maximum #(
	parameter int unsigned WINDOW_MAX   = 64,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           window_length_write,
	input  logic [swm_pkg::WL_W-1:0]       window_length,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           last_of_sequence,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [SAMPLE_WIDTH-1:0] window_max,
	output logic                           sequence_end
);

	localparam int unsigned POS_MOD = 2 * WINDOW_MAX;
	localparam int unsigned POS_W   = $clog2(POS_MOD);
	localparam int unsigned CNT_W   = $clog2(WINDOW_MAX + 1);

	// Config
	logic [swm_pkg::WL_W-1:0] wl_q;
	logic [CNT_W-1:0]         k_eff;

	// Sequence counters
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [CNT_W-1:0] filled_q;
	logic [CNT_W-1:0] filled_inc;

	// Cell row; index 0 is the oldest candidate
	logic                           cell_valid [WINDOW_MAX];
	logic [POS_W-1:0]               cell_pos   [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
	logic                           cell_keep  [WINDOW_MAX];

	swm_pkg::swm_ctrl_t ctrl;
	logic               front_exp;
	logic               second_exp;
	logic               trim;
	logic               accept;
	logic               produce;

	logic                           front_src_valid;
	logic signed [SAMPLE_WIDTH-1:0] front_src_value;
	logic signed [SAMPLE_WIDTH-1:0] max_d;

	// Output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] window_max_q;
	logic                           sequence_end_q;

	// Age of an entry relative to the current position, modulo POS_MOD
	function automatic logic [POS_W-1:0] age_of(input logic [POS_W-1:0] now,
		input logic [POS_W-1:0] then_pos);
		logic [POS_W:0] diff;
		diff = {1'b0, now} - {1'b0, then_pos};
		if (diff[POS_W]) begin
			diff = diff + (POS_W+1)'(POS_MOD);
		end
		return diff[POS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= swm_pkg::WL_RESET;
		end else if (window_length_write) begin
			wl_q <= window_length;
		end
	end

	// Zero acts as 1, anything above the row depth acts as the depth
	always_comb begin
		if (wl_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (int'(wl_q) > int'(WINDOW_MAX)) begin
			k_eff = CNT_W'(WINDOW_MAX);
		end else begin
			k_eff = CNT_W'(wl_q);
		end
	end

	// Ages along the row fall from the front, so expiry is a prefix.
	// With a steady window at most the front expires per sample; more
	// than one happens only after the window shrank and is trimmed first.
	assign front_exp  = cell_valid[0] &&
		(age_of(pos_q, cell_pos[0]) >= POS_W'(k_eff));
	assign second_exp = cell_valid[1] &&
		(age_of(pos_q, cell_pos[1]) >= POS_W'(k_eff));
	assign trim       = front_exp & second_exp;

	assign sample_stall = trim | (out_valid_q & result_stall);
	assign accept       = sample_valid & ~sample_stall;

	assign ctrl.load  = accept;
	assign ctrl.shift = trim | (accept & front_exp);
	assign ctrl.clear = accept & last_of_sequence;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                           r_valid;
		logic [POS_W-1:0]               r_pos;
		logic signed [SAMPLE_WIDTH-1:0] r_value;
		logic                           l_keep;

		if (i == WINDOW_MAX - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_pos   = '0;
			assign r_value = '0;
		end else begin : g_mid
			assign r_valid = cell_valid[i+1];
			assign r_pos   = cell_pos[i+1];
			assign r_value = cell_value[i+1];
		end

		if (i == 0) begin : g_head
			assign l_keep = 1'b1;
		end else begin : g_body
			assign l_keep = cell_keep[i-1];
		end

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.POS_W        (POS_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_sample  (sample),
			.new_pos     (pos_q),
			.left_keep   (l_keep),
			.right_valid (r_valid),
			.right_pos   (r_pos),
			.right_value (r_value),
			.valid       (cell_valid[i]),
			.pos         (cell_pos[i]),
			.value       (cell_value[i]),
			.keep        (cell_keep[i])
		);
	end

	// Front after this sample: surviving head, or the new sample itself
	assign front_src_valid = front_exp ? cell_valid[1] : cell_valid[0];
	assign front_src_value = front_exp ? cell_value[1] : cell_value[0];
	assign max_d = (front_src_valid && (front_src_value > sample)) ?
		front_src_value : sample;

	assign filled_inc = (filled_q < k_eff) ? filled_q + CNT_W'(1) : filled_q;
	assign produce    = (filled_inc >= k_eff);
	assign pos_next   = (pos_q == POS_W'(POS_MOD - 1)) ? '0 : pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= '0;
		end else if (accept) begin
			if (last_of_sequence) begin
				pos_q    <= '0;
				filled_q <= '0;
			end else begin
				pos_q    <= pos_next;
				filled_q <= filled_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= produce;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_max_q   <= max_d;
			sequence_end_q <= last_of_sequence;
		end
	end

	assign result_valid = out_valid_q;
	assign window_max   = window_max_q;
	assign sequence_end = sequence_end_q;

endmodule

[rtl/swm_cell.sv]
`timescale 1ns / 1ps

module swm_cell #(
	parameter int unsigned SAMPLE_WIDTH = 16,
	parameter int unsigned POS_W        = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::swm_ctrl_t             ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
	input  logic [POS_W-1:0]               new_pos,
	input  logic                           left_keep,
	input  logic                           right_valid,
	input  logic [POS_W-1:0]               right_pos,
	input  logic signed [SAMPLE_WIDTH-1:0] right_value,
	output logic                           valid,
	output logic [POS_W-1:0]               pos,
	output logic signed [SAMPLE_WIDTH-1:0] value,
	output logic                           keep
);

	logic                           valid_q;
	logic [POS_W-1:0]               pos_q;
	logic signed [SAMPLE_WIDTH-1:0] value_q;

	logic                           src_valid;
	logic [POS_W-1:0]               src_pos;
	logic signed [SAMPLE_WIDTH-1:0] src_value;
	logic                           valid_d;
	logic [POS_W-1:0]               pos_d;
	logic signed [SAMPLE_WIDTH-1:0] value_d;

	// Entry this cell would hold after the front drop
	assign src_valid = ctrl.shift ? right_valid : valid_q;
	assign src_pos   = ctrl.shift ? right_pos   : pos_q;
	assign src_value = ctrl.shift ? right_value : value_q;

	// Survives the pop only if strictly greater than the new sample
	assign keep = src_valid & (!ctrl.load || (src_value > new_sample));

	always_comb begin
		valid_d = valid_q;
		pos_d   = pos_q;
		value_d = value_q;
		if (ctrl.load) begin
			if (keep) begin
				valid_d = 1'b1;
				pos_d   = src_pos;
				value_d = src_value;
			end else if (left_keep) begin
				// first free slot behind the kept run: append here
				valid_d = 1'b1;
				pos_d   = new_pos;
				value_d = new_sample;
			end else begin
				valid_d = 1'b0;
			end
			if (ctrl.clear) begin
				valid_d = 1'b0;
			end
		end else if (ctrl.shift) begin
			valid_d = src_valid;
			pos_d   = src_pos;
			value_d = src_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		value_q <= value_d;
	end

	assign valid = valid_q;
	assign pos   = pos_q;
	assign value = value_q;

endmodule

[rtl/swm_checker.sv]
`timescale 1ns / 1ps

module swm_checker #(
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_valid,
	input logic                           sample_stall,
	input logic                           last_of_sequence,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic signed [SAMPLE_WIDTH-1:0] window_max,
	input logic                           sequence_end
);

	// Held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(window_max) && $stable(sequence_end))
		else $error("stalled result changed");

	// No new request while a result is held back
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> sample_stall)
		else $error("request taken over a held result");

	// Results only follow a taken request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_valid && !sample_stall) && !(result_valid && result_stall) |=>
			!result_valid)
		else $error("result without request");

	// End flag only for the last sample of a sequence
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !last_of_sequence |=>
			!(result_valid && sequence_end))
		else $error("sequence_end on a non-final sample");

endmodule

bind sliding_window_maximum swm_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample_valid),
	.sample_stall     (sample_stall),
	.last_of_sequence (last_of_sequence),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.window_max       (window_max),
	.sequence_end     (sequence_end)
);
